[rtl/core/buzq_pkg.sv]
// Shared types and constants for the buzzer pattern queue.
package buzq_pkg;

	// Item kinds carried on the kind port.
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_APPEND  = 2'd1;
	localparam logic [1:0] KIND_PATTERN = 2'd2;

	// Width of the fill count reported with each result.
	localparam int FILL_OUT_W = 7;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_POP  = 5'b00100,
		ST_FILL = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	// Phase of a pattern period.
	typedef enum logic {
		PH_HIGH = 1'b0,
		PH_LOW  = 1'b1
	} phase_t;

endpackage

[rtl/core/buzq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module buzq_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/buzzer_pattern_queue_core.sv]
// Top level of the buzzer pattern queue: sequencer, pointers and level store.
//
// Usage. One command channel: a transaction is taken at a rising edge with start
// high and busy low; kind selects tick (pop one level and drive the pin), append
// (add one level) or pattern (append high_count ones then low_count zeros, for
// each of periods periods). Every transaction gives exactly one result, shown for
// one cycle with result_valid high: pin_drive (0 sounds, 1 off), fill_count and
// dropped (some appended level was discarded because the queue was full).
// An append, an unused kind and a tick on an empty queue go from idle straight
// to the result state; a tick that pops passes through the read and pop states
// first, as the level store has one write port and a registered read port. A
// pattern passes through the fill state, pausing at each high/low phase
// boundary, and stops early when the queue fills. The shared store port writes
// one level per cycle while a pattern is not at a phase boundary.
// busy is high from acceptance until the result cycle has ended.
// Reset empties the queue and sets the pin to 1 (off); the store needs no
// clearing pass, as only written entries are read. The receiver cannot stall
// results, so none is ever held back.
module buzzer_pattern_queue_core #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic       level,
	input  logic [7:0] high_count,
	input  logic [7:0] low_count,
	input  logic [7:0] periods,
	output logic       result_valid,
	output logic       pin_drive,
	output logic [6:0] fill_count,
	output logic       dropped
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

	buzq_pkg::state_t state_q;
	buzq_pkg::phase_t phase_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [FW-1:0] fill_q;
	logic          pin_q;
	logic          dropped_q;
	logic [7:0]    hi_q;
	logic [7:0]    lo_q;
	logic [7:0]    per_q;
	logic [7:0]    cnt_q;

	logic          accept;
	logic          full;
	logic          push_req;
	logic          push_val;
	logic          ram_we;
	logic          rd_level;

	assign accept = start && (state_q == buzq_pkg::ST_IDLE);
	assign full   = (fill_q == FULL_FILL);

	// Decide whether a level is to be appended this cycle, and which.
	always_comb begin
		push_req = 1'b0;
		push_val = 1'b0;
		if (accept && (kind == buzq_pkg::KIND_APPEND)) begin
			push_req = 1'b1;
			push_val = level;
		end else if ((state_q == buzq_pkg::ST_FILL) && (per_q != 8'd0)) begin
			if ((phase_q == buzq_pkg::PH_HIGH) && (cnt_q != hi_q)) begin
				push_req = 1'b1;
				push_val = 1'b1;
			end else if ((phase_q == buzq_pkg::PH_LOW) && (cnt_q != lo_q)) begin
				push_req = 1'b1;
				push_val = 1'b0;
			end
		end
	end

	assign ram_we = push_req && !full;

	// Level store.
	buzq_ram #(
		.WIDTH (1),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (push_val),
		.raddr (head_q),
		.rdata (rd_level)
	);

	// Sequencer, queue pointers and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= buzq_pkg::ST_IDLE;
			phase_q   <= buzq_pkg::PH_HIGH;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			pin_q     <= 1'b1;
			dropped_q <= 1'b0;
			hi_q      <= 8'd0;
			lo_q      <= 8'd0;
			per_q     <= 8'd0;
			cnt_q     <= 8'd0;
		end else begin
			// Append path shared by single appends and patterns.
			if (ram_we) begin
				tail_q <= (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);
				fill_q <= fill_q + FW'(1);
			end
			case (state_q)
				buzq_pkg::ST_IDLE: begin
					if (accept) begin
						dropped_q <= 1'b0;
						hi_q      <= high_count;
						lo_q      <= low_count;
						per_q     <= periods;
						cnt_q     <= 8'd0;
						phase_q   <= buzq_pkg::PH_HIGH;
						state_q   <= buzq_pkg::ST_DONE;
						case (kind)
							buzq_pkg::KIND_TICK: begin
								if (fill_q == '0) begin
									pin_q <= 1'b1;
								end else begin
									state_q <= buzq_pkg::ST_READ;
								end
							end
							buzq_pkg::KIND_APPEND: begin
								dropped_q <= full;
							end
							buzq_pkg::KIND_PATTERN: begin
								state_q <= buzq_pkg::ST_FILL;
							end
							default: begin
							end
						endcase
					end
				end
				buzq_pkg::ST_READ: begin
					state_q <= buzq_pkg::ST_POP;
				end
				buzq_pkg::ST_POP: begin
					pin_q   <= ~rd_level;
					head_q  <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
					fill_q  <= fill_q - FW'(1);
					state_q <= buzq_pkg::ST_DONE;
				end
				buzq_pkg::ST_FILL: begin
					if (per_q == 8'd0) begin
						state_q <= buzq_pkg::ST_DONE;
					end else if (push_req) begin
						if (full) begin
							dropped_q <= 1'b1;
							state_q   <= buzq_pkg::ST_DONE;
						end else begin
							cnt_q <= cnt_q + 8'd1;
						end
					end else if (phase_q == buzq_pkg::PH_HIGH) begin
						phase_q <= buzq_pkg::PH_LOW;
						cnt_q   <= 8'd0;
					end else begin
						phase_q <= buzq_pkg::PH_HIGH;
						cnt_q   <= 8'd0;
						per_q   <= per_q - 8'd1;
					end
				end
				buzq_pkg::ST_DONE: begin
					state_q <= buzq_pkg::ST_IDLE;
				end
				default: begin
					state_q <= buzq_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Result transaction.
	assign busy         = (state_q != buzq_pkg::ST_IDLE);
	assign result_valid = (state_q == buzq_pkg::ST_DONE);
	assign pin_drive    = pin_q;
	assign fill_count   = buzq_pkg::FILL_OUT_W'(fill_q);
	assign dropped      = dropped_q;

endmodule
